// ----- design/sptd_pkg.sv -----
// ----------------------------------------------------------------------------
// sptd_pkg
// Shared types and constants for the telemetry deframer.
// ----------------------------------------------------------------------------
package sptd_pkg;

    localparam logic [7:0] ESC_BYTE          = 8'h7D;
    localparam logic [7:0] ESC_ADD           = 8'h20;
    localparam logic [7:0] FRAME_START_RESET = 8'h10;

    localparam int         PAYLOAD_LEN   = 6;
    localparam int         PAYLOAD_BITS  = 8 * PAYLOAD_LEN;

    // frame position: idle, payload bytes 1..6, then checksum
    localparam logic [2:0] POS_IDLE  = 3'd0;
    localparam logic [2:0] POS_CHECK = 3'd7;

    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int         QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one unescaped byte moving between stages
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_xfer;

endpackage

// ----- design/sptd_front.sv -----
// ----------------------------------------------------------------------------
// sptd_front
// Input side: accepts raw bytes, strips escapes, pushes data bytes.
// ----------------------------------------------------------------------------
module sptd_front import sptd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_not_full,
    output t_byte_xfer o_push
);

    logic r_esc;
    logic n_esc;
    logic accept;
    logic swallow;

    assign o_in_ready = i_q_not_full;
    assign accept     = i_in_valid && i_q_not_full;
    assign swallow    = !r_esc && (i_in_byte == ESC_BYTE);

    always_comb begin
        o_push.valid = accept && !swallow;
        o_push.data  = r_esc ? (i_in_byte + ESC_ADD) : i_in_byte;
        n_esc        = r_esc;
        if (accept) begin
            n_esc = swallow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

endmodule

// ----- design/sptd_queue.sv -----
// ----------------------------------------------------------------------------
// sptd_queue
// Short FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module sptd_queue import sptd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_byte_xfer i_push,
    input  logic       i_pop,
    output logic       o_not_full,
    output t_byte_xfer o_head
);

    logic [7:0]          r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_CW-1:0] n_count;
    logic                do_push;
    logic                do_pop;

    assign o_not_full  = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && o_not_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QUEUE_CW'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push lost");

endmodule

// ----- design/sptd_back.sv -----
// ----------------------------------------------------------------------------
// sptd_back
// Frame tracker: start match, payload capture, checksum, result register.
// ----------------------------------------------------------------------------
module sptd_back import sptd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_byte_xfer  i_head,
    output logic        o_pop,
    input  logic [7:0]  i_start_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sensor_id,
    output logic [31:0] o_sensor_value
);

    logic [2:0]              r_pos;
    logic [2:0]              n_pos;
    logic [7:0]              r_sum;
    logic [7:0]              n_sum;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [15:0]             r_id;
    logic [31:0]             r_value;
    logic [8:0]              sum_raw;
    logic                    good;
    logic [7:0]              b;

    assign b       = i_head.data;
    assign o_pop   = i_head.valid && (!r_out_valid || i_out_ready);
    // end-around carry
    assign sum_raw = {1'b0, r_sum} + {1'b0, b};
    assign good    = o_pop && (r_pos == POS_CHECK) && (~r_sum == b);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (o_pop) begin
            if (r_pos == POS_IDLE) begin
                if (b == i_start_byte) begin
                    n_pos = 3'd1;
                    n_sum = i_start_byte;
                end
            end else if (r_pos == POS_CHECK) begin
                n_pos = POS_IDLE;
            end else begin
                n_pos = r_pos + 3'd1;
                n_sum = sum_raw[7:0] + {7'd0, sum_raw[8]};
            end
        end
        n_out_valid = good || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (o_pop && r_pos != POS_IDLE && r_pos != POS_CHECK) begin
            r_payload <= {b, r_payload[PAYLOAD_BITS-1:8]};
        end
        if (good) begin
            r_id    <= r_payload[15:0];
            r_value <= r_payload[47:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sensor_id    = r_id;
    assign o_sensor_value = r_value;

    a_result_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_pos) == POS_CHECK && $past(o_pop)))
        else $error("result without checksum byte");

    a_check_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_pos == POS_CHECK) |=> (r_pos == POS_IDLE))
        else $error("frame did not close after checksum");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_id) && $stable(r_value)))
        else $error("pending result overwritten");

endmodule

// ----- design/smartport_telemetry_deframer_core.sv -----
// Result: a result is presented in the cycle after its checksum byte leaves the queue.
// Throughput: one input byte per cycle while the byte queue is not full; its 4
// entries absorb stalls while a result waits in the output register.
// Reset: synchronous, active low; clears the escape flag, queue, frame position
// and output valid; the frame start byte returns to 0x10.
// ----------------------------------------------------------------------------
// smartport_telemetry_deframer_core
// Byte-stream telemetry deframer: unescape, frame, checksum, sensor result.
// ----------------------------------------------------------------------------
module smartport_telemetry_deframer_core import sptd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sensor_id,
    output logic [31:0] o_sensor_value,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic [7:0] r_start_byte;
    t_byte_xfer push;
    t_byte_xfer head;
    logic       q_not_full;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= FRAME_START_RESET;
        end else if (i_cfg_wr_en) begin
            r_start_byte <= i_cfg_wr_data;
        end
    end

    sptd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_q_not_full (q_not_full),
        .o_push       (push)
    );

    sptd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_not_full (q_not_full),
        .o_head     (head)
    );

    sptd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_start_byte   (r_start_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sensor_id    (o_sensor_id),
        .o_sensor_value (o_sensor_value)
    );

endmodule

// ----- tb/smartport_telemetry_deframer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartport_telemetry_deframer_core_test
// Drives escaped byte streams through the deframer, tracks the frame state in
// a local predictor and checks every sensor result in order. The start byte is
// reprogrammed between phases, once in the middle of a frame.
// ----------------------------------------------------------------------------
module smartport_telemetry_deframer_core_test;
    import sptd_pkg::*;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] value;
    } t_sensor_reading;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] sensor_id;
    logic [31:0] sensor_value;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;

    smartport_telemetry_deframer_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_sensor_id    (sensor_id),
        .o_sensor_value (sensor_value),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    initial forever #5 clk = ~clk;

    // raw bytes waiting to be driven, and sensor results still owed by the dut
    logic [7:0]      byte_backlog [$];
    t_sensor_reading sensor_expect [$];

    int mismatch_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit in_burst = 1'b0;
    bit out_burst = 1'b0;

    // predictor state
    logic [7:0]  start_copy = FRAME_START_RESET;
    logic        esc_armed = 1'b0;
    logic [2:0]  frame_pos = POS_IDLE;
    logic [47:0] payload_seen = '0;
    logic [7:0]  frame_sum = '0;

    // 8-bit add with end-around carry
    function automatic logic [7:0] eac_add(input logic [7:0] acc, input logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic logic [7:0] frame_check(input logic [7:0] seed,
                                               input logic [47:0] payload);
        logic [7:0] acc;
        acc = seed;
        for (int i = 0; i < PAYLOAD_LEN; i++) acc = eac_add(acc, payload[8*i +: 8]);
        return ~acc;
    endfunction

    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0]      b;
        t_sensor_reading rd;
        if (!esc_armed && raw == ESC_BYTE) begin
            esc_armed = 1'b1;
        end else begin
            b = esc_armed ? raw + ESC_ADD : raw;
            esc_armed = 1'b0;
            if (frame_pos == POS_IDLE) begin
                if (b == start_copy) begin
                    frame_sum = start_copy;
                    frame_pos = 3'd1;
                end
            end else if (frame_pos != POS_CHECK) begin
                payload_seen[8*(frame_pos-1) +: 8] = b;
                frame_sum = eac_add(frame_sum, b);
                frame_pos = frame_pos + 3'd1;
            end else begin
                frame_pos = POS_IDLE;
                if ((~frame_sum) == b) begin
                    rd.id    = payload_seen[15:0];
                    rd.value = payload_seen[47:16];
                    sensor_expect.push_back(rd);
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // sender side
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && in_ready) begin
                deframe_byte(in_byte);
                gap_left = in_burst ? 0 : $urandom_range(0, 9);
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_backlog.size() > 0) begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    t_sensor_reading want;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (sensor_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result id %h value %h",
                                            sensor_id, sensor_value));
                end else begin
                    want = sensor_expect.pop_front();
                    if (sensor_id !== want.id)
                        flag_mismatch($sformatf("sensor_id %h, expected %h",
                                                sensor_id, want.id));
                    if (sensor_value !== want.value)
                        flag_mismatch($sformatf("sensor_value %h, expected %h",
                                                sensor_value, want.value));
                end
                stall_left = out_burst ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // --- stimulus helpers ---

    // escape 0x7D always and when forced, other bytes now and then
    task automatic put_byte(input logic [7:0] b, input bit forced);
        if (forced || b == ESC_BYTE || $urandom_range(0, 7) == 0) begin
            byte_backlog.push_back(ESC_BYTE);
            byte_backlog.push_back(b - ESC_ADD);
        end else begin
            byte_backlog.push_back(b);
        end
    endtask

    task automatic put_frame(input logic [7:0] seed, input logic [47:0] payload,
                             input logic [7:0] corrupt);
        put_byte(seed, 1'b0);
        for (int i = 0; i < PAYLOAD_LEN; i++) put_byte(payload[8*i +: 8], 1'b0);
        put_byte(frame_check(seed, payload) ^ corrupt, 1'b0);
    endtask

    function automatic logic [47:0] random_payload();
        logic [47:0] p;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case ($urandom_range(0, 9))
                0:       p[8*i +: 8] = 8'h00;
                1:       p[8*i +: 8] = 8'hFF;
                default: p[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // wait for the dut to drain everything, then let the internal queue empty
    task automatic settle();
        @(negedge clk);
        while (byte_backlog.size() != 0 || in_valid || sensor_expect.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        start_copy = v;
    endtask

    task automatic random_phase(input int n_items);
        logic [47:0] p;
        int          cut;
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
        @(negedge clk);
        while (byte_backlog.size() < n_items) begin
            p = random_payload();
            case ($urandom_range(0, 9))
                7: put_frame(start_copy, p, 8'($urandom_range(1, 255)));
                8: begin
                    // truncated frame, the next bytes get absorbed into it
                    cut = $urandom_range(0, 5);
                    put_byte(start_copy, 1'b0);
                    for (int i = 0; i < cut; i++) put_byte(p[8*i +: 8], 1'b0);
                end
                9: begin
                    // raw noise, may leave an escape armed
                    cut = $urandom_range(1, 4);
                    for (int i = 0; i < cut; i++)
                        byte_backlog.push_back(8'($urandom_range(0, 255)));
                end
                default: put_frame(start_copy, p, 8'h00);
            endcase
        end
    endtask

    logic [47:0] split_payload;
    logic [7:0]  phase_start [8];

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with the reset start byte
        @(negedge clk);
        byte_backlog.push_back(ESC_BYTE);      // escape of an escape, 0x9D while idle
        byte_backlog.push_back(ESC_BYTE);
        put_byte(FRAME_START_RESET, 1'b1);     // start byte only seen after unescaping
        for (int i = 0; i < PAYLOAD_LEN; i++) put_byte(8'h00, 1'b0);
        put_byte(frame_check(FRAME_START_RESET, '0), 1'b0);
        put_frame(FRAME_START_RESET, {48{1'b1}}, 8'h01);   // bad checksum, dropped
        // start byte and escaped 0x9D / 0x7D as payload; frame straddles a reconfig
        split_payload = {8'hA5, 8'h00, 8'hFF, 8'h7D, 8'h9D, FRAME_START_RESET};
        put_byte(FRAME_START_RESET, 1'b0);
        put_byte(split_payload[7:0], 1'b0);
        put_byte(split_payload[15:8], 1'b1);
        put_byte(split_payload[23:16], 1'b0);
        settle();

        write_start_byte(8'hFF);
        @(negedge clk);
        for (int i = 3; i < PAYLOAD_LEN; i++) put_byte(split_payload[8*i +: 8], 1'b0);
        put_byte(frame_check(FRAME_START_RESET, split_payload), 1'b0);
        put_frame(8'hFF, {48{1'b1}}, 8'h00);
        settle();

        phase_start[0] = 8'h00;
        phase_start[1] = ESC_BYTE;
        phase_start[2] = 8'h9D;
        phase_start[3] = 8'hFF;
        for (int ph = 4; ph < 8; ph++) phase_start[ph] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 8; ph++) begin
            write_start_byte(phase_start[ph]);
            random_phase(96);
            settle();
        end

        if (mismatch_count == 0)
            $display("smartport_telemetry_deframer_core_test: clean");
        else
            $display("smartport_telemetry_deframer_core_test: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("smartport_telemetry_deframer_core_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/sptd_pkg.sv
design/sptd_front.sv
design/sptd_queue.sv
design/sptd_back.sv
design/smartport_telemetry_deframer_core.sv
tb/smartport_telemetry_deframer_core_test.sv
